@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the COBS frame decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define CFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define CFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define CFD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/cfd_pkg.sv @@
// Package with the shared types and result codes of the COBS frame decoder.
`timescale 1ns / 1ps
package cfd_pkg;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ABORT = 2'd2
  } cfd_kind_t;

  localparam logic [7:0] CODE_FULL_GROUP = 8'hFF;

  // Byte held in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } cfd_item_t;

  // Result handed from the decoder to the output register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    cfd_kind_t  kind;
  } cfd_result_t;

endpackage

@@ rtl/cfd_ifs.sv @@
// Valid/ready channel interfaces for input bytes, results and the marker register.
`timescale 1ns / 1ps

interface cfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface cfd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  modport source (output valid, output out_byte, output out_kind, input ready);
  modport sink (input valid, input out_byte, input out_kind, output ready);
endinterface

interface cfd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] marker_value;
  modport source (output valid, output marker_value, input ready);
  modport sink (input valid, input marker_value, output ready);
endinterface

@@ rtl/cobs_frame_decoder_top.sv @@
// A byte taken into the input register is decoded combinationally; its result enters the output register once free.
// Throughput: one encoded byte per cycle while results are not stalled, set by the single decode state update.
// A stalled result lets the input register take one more byte, then holds in_ready low.
// Reset (rst_n low, synchronous) returns to idle awaiting an opening marker, marker 0.
// Top level of the COBS frame decoder.
`timescale 1ns / 1ps
module cobs_frame_decoder_top
  import cfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  cfd_byte_if.sink     in_if,
  cfd_result_if.source out_if,
  cfd_cfg_if.sink      cfg_if
);

  cfd_item_t   item;
  cfd_result_t result;
  logic        out_free;
  logic        advance;

  assign advance = item.valid && out_free;

  cfd_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_byte  (in_if.in_byte),
    .in_ready (in_if.ready),
    .out_free (out_free),
    .item     (item)
  );

  cfd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_if  (cfg_if),
    .item    (item),
    .advance (advance),
    .result  (result)
  );

  cfd_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .result   (result),
    .out_free (out_free),
    .out_if   (out_if)
  );

endmodule

@@ rtl/cfd_in_stage.sv @@
// Input register that captures one encoded byte per transaction.
`timescale 1ns / 1ps
module cfd_in_stage
  import cfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic [7:0] in_byte,
  output logic      in_ready,
  input  logic      out_free,
  output cfd_item_t item
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       take;

  // The held byte moves on whenever the output register can take its result.
  assign in_ready  = !valid_r || out_free;
  assign take      = in_valid && in_ready;
  assign valid_nxt = take ? 1'b1 : (out_free ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_byte;
    end
  end

  assign item.valid = valid_r;
  assign item.data  = data_r;

endmodule

@@ rtl/cfd_decode.sv @@
// Frame state machine and marker register; decodes one byte per cycle while advance is high.
`timescale 1ns / 1ps
module cfd_decode
  import cfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  cfd_cfg_if.sink     cfg_if,
  input  cfd_item_t   item,
  input  logic        advance,
  output cfd_result_t result
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_CODE  = 2'd1,
    PH_GROUP = 2'd2
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] left_r, left_nxt;
  logic       owed_r, owed_nxt;
  logic [7:0] marker_r;
  logic [7:0] b;
  logic [7:0] left_dec;
  logic       is_marker;

  assign cfg_if.ready = 1'b1;

  assign b         = item.data;
  assign is_marker = (b == marker_r);
  assign left_dec  = left_r - 8'd1;

  always_comb begin
    phase_nxt   = phase_r;
    left_nxt    = left_r;
    owed_nxt    = owed_r;
    result.valid = 1'b0;
    result.data  = 8'd0;
    result.kind  = KIND_DATA;
    case (phase_r)
      PH_CODE: begin
        if (is_marker) begin
          phase_nxt    = PH_IDLE;
          left_nxt     = 8'd0;
          owed_nxt     = 1'b0;
          result.valid = 1'b1;
          result.kind  = KIND_END;
        end else if (b == 8'd0) begin
          phase_nxt    = PH_IDLE;
          left_nxt     = 8'd0;
          owed_nxt     = 1'b0;
          result.valid = 1'b1;
          result.kind  = KIND_ABORT;
        end else begin
          left_nxt  = b - 8'd1;
          owed_nxt  = (b != CODE_FULL_GROUP);
          phase_nxt = (b != 8'd1) ? PH_GROUP : PH_CODE;
          // The marker implied by the previous code goes out only now.
          if (owed_r) begin
            result.valid = 1'b1;
            result.data  = marker_r;
          end
        end
      end
      PH_GROUP: begin
        if (is_marker) begin
          phase_nxt    = PH_IDLE;
          left_nxt     = 8'd0;
          owed_nxt     = 1'b0;
          result.valid = 1'b1;
          result.kind  = KIND_ABORT;
        end else begin
          left_nxt     = left_dec;
          phase_nxt    = (left_dec == 8'd0) ? PH_CODE : PH_GROUP;
          result.valid = 1'b1;
          result.data  = b;
        end
      end
      default: begin
        // Idle and the unused phase code both wait for an opening marker.
        phase_nxt = is_marker ? PH_CODE : PH_IDLE;
        left_nxt  = 8'd0;
        owed_nxt  = 1'b0;
      end
    endcase
    if (!advance) begin
      phase_nxt    = phase_r;
      left_nxt     = left_r;
      owed_nxt     = owed_r;
      result.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      left_r   <= 8'd0;
      owed_r   <= 1'b0;
      marker_r <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      owed_r  <= owed_nxt;
      if (cfg_if.valid) begin
        marker_r <= cfg_if.marker_value;
      end
    end
  end

endmodule

@@ rtl/cfd_out_stage.sv @@
// Output register that holds one result until the sink takes it.
`timescale 1ns / 1ps
module cfd_out_stage
  import cfd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  cfd_result_t   result,
  output logic          out_free,
  cfd_result_if.source  out_if
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  cfd_kind_t  kind_r;

  assign out_free  = !valid_r || out_if.ready;
  assign valid_nxt = out_free ? result.valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && result.valid) begin
      data_r <= result.data;
      kind_r <= result.kind;
    end
  end

  assign out_if.valid    = valid_r;
  assign out_if.out_byte = data_r;
  assign out_if.out_kind = kind_r;

endmodule

@@ rtl/cfd_checker.sv @@
// Port-level checker for the COBS frame decoder and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cfd_checker
  import cfd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] out_kind
);

  logic       stall;
  logic [9:0] payload;
  logic       kind_ok;
  logic       ctl_result;

  assign stall      = out_valid && !out_ready;
  assign payload    = {out_byte, out_kind};
  assign kind_ok    = (out_kind == KIND_DATA) || (out_kind == KIND_END) ||
                      (out_kind == KIND_ABORT);
  assign ctl_result = out_valid && (out_kind != KIND_DATA);

  `CFD_ASSERT_NEXT(a_out_hold, clk, rst_n, stall, out_valid && $stable(payload), "held result changed")
  `CFD_ASSERT_NOW(a_kind_code, clk, rst_n, out_valid, kind_ok, "result kind out of range")
  `CFD_ASSERT_NOW(a_end_zero, clk, rst_n, ctl_result, out_byte == 8'd0, "nonzero byte on end or abort")
  `CFD_ASSERT_NOW(a_ready_empty, clk, rst_n, !out_valid, in_ready, "input stalled with empty output")
  `CFD_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid, "result present after reset")

endmodule

bind cobs_frame_decoder_top cfd_checker u_cfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_byte  (out_if.out_byte),
  .out_kind  (out_if.out_kind)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the COBS frame decoder with a scoreboard class.
`timescale 1ns / 1ps
module testbench
  import cfd_pkg::*;
;

  localparam int LIMIT_CYCLES = 400000;
  localparam int QUOTA        = 950;
  localparam int SETTLE       = 8;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CODE  = 2'd1,
    ST_GROUP = 2'd2
  } frame_state_t;

  typedef struct {
    logic [7:0] data;
    cfd_kind_t  kind;
  } decoded_t;

  class cobs_scoreboard;
    decoded_t     pending[$];
    logic [7:0]   marker;
    frame_state_t phase;
    logic [7:0]   left;
    bit           owed;
    int           mismatches;

    function new();
      marker     = 8'h00;
      mismatches = 0;
      go_idle();
    endfunction

    function void go_idle();
      phase = ST_IDLE;
      left  = 8'h00;
      owed  = 1'b0;
    endfunction

    function void push(logic [7:0] d, cfd_kind_t k);
      decoded_t r;
      r.data = d;
      r.kind = k;
      pending.push_back(r);
    endfunction

    // Returns 0 when the byte is dropped while waiting for an opening marker.
    function bit note_byte(logic [7:0] b);
      bit was_owed;
      case (phase)
        ST_CODE: begin
          if (b == marker) begin
            go_idle();
            push(8'h00, KIND_END);
          end else if (b == 8'h00) begin
            go_idle();
            push(8'h00, KIND_ABORT);
          end else begin
            was_owed = owed;
            left     = b - 8'd1;
            owed     = (b != CODE_FULL_GROUP);
            phase    = (left != 8'h00) ? ST_GROUP : ST_CODE;
            if (was_owed) push(marker, KIND_DATA);
          end
        end
        ST_GROUP: begin
          if (b == marker) begin
            go_idle();
            push(8'h00, KIND_ABORT);
          end else begin
            left = left - 8'd1;
            if (left == 8'h00) phase = ST_CODE;
            push(b, KIND_DATA);
          end
        end
        default: begin
          if (b != marker) return 1'b0;
          phase = ST_CODE;
          left  = 8'h00;
          owed  = 1'b0;
        end
      endcase
      return 1'b1;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic [7:0] d, logic [1:0] k);
      decoded_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result byte %h kind %0d", d, k));
      end else begin
        e = pending.pop_front();
        if (d !== e.data)
          report($sformatf("out_byte %h, expected %h", d, e.data));
        if (k !== e.kind)
          report($sformatf("out_kind %0d, expected %0d", k, e.kind));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  cfd_byte_if   in_if();
  cfd_result_if out_if();
  cfd_cfg_if    cfg_if();

  cobs_scoreboard sb = new();
  int         cycles;
  int         useful_items;
  bit         steady;
  logic [7:0] cur_marker;

  cobs_frame_decoder_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.in_byte       = 8'h00;
    out_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.marker_value = 8'h00;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // The sink side stalls at random except during the steady stretch.
  always @(negedge clk) begin
    out_if.ready <= steady || ($urandom_range(0, 99) >= 11);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        if (sb.note_byte(in_if.in_byte)) useful_items++;
      end
      if (cfg_if.valid && cfg_if.ready) sb.marker = cfg_if.marker_value;
      if (out_if.valid && out_if.ready) sb.check_result(out_if.out_byte, out_if.out_kind);
    end
  end

  task send_byte(logic [7:0] b);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 11) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid   = 1'b1;
    in_if.in_byte = b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Drops valid and lets every expected result drain before going on.
  task drain();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task write_marker(logic [7:0] m);
    drain();
    @(negedge clk);
    cfg_if.valid        = 1'b1;
    cfg_if.marker_value = m;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid = 1'b0;
    cur_marker   = m;
  endtask

  function logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == cur_marker);
    return b;
  endfunction

  // One frame, at times after stray bytes, mostly well formed, sometimes broken by a zero code, an early
  // marker inside a group, or a missing closing marker.
  task run_frame();
    int         groups;
    int         n;
    int         pick;
    logic [7:0] code;
    if ($urandom_range(0, 99) < 20) begin
      repeat ($urandom_range(1, 3)) send_byte(plain_byte());
    end
    send_byte(cur_marker);
    groups = $urandom_range(1, 4);
    for (int g = 0; g < groups; g++) begin
      pick = $urandom_range(0, 99);
      if (pick == 0) code = CODE_FULL_GROUP;
      else if (pick < 4 && cur_marker != 8'h00) code = 8'h00;
      else if (pick < 7) code = 8'($urandom_range(1, 255));
      else code = 8'($urandom_range(1, 12));
      send_byte(code);
      if (code == 8'h00 || code == cur_marker) return;
      n = int'(code) - 1;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 299) == 0) begin
          send_byte(cur_marker);
          return;
        end
        send_byte(plain_byte());
      end
    end
    if ($urandom_range(0, 9) != 0) send_byte(cur_marker);
  endtask

  initial begin
    logic [7:0] seq_zero[]  = '{8'h37, 8'h00, 8'h03, 8'hAA, 8'hFF, 8'h01, 8'h02, 8'h01,
                                8'h00, 8'h00, 8'h05, 8'h11, 8'h00, 8'h00, 8'h00};
    logic [7:0] seq_ones[]  = '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h03, 8'h12, 8'h34,
                                8'hFF, 8'h80};
    logic [7:0] markers[6]  = '{8'h00, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h7E};
    int         target;
    cycles       = 0;
    useful_items = 0;
    steady       = 1'b0;
    cur_marker   = 8'h00;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed part under the reset marker, then with an all-ones marker.
    foreach (seq_zero[i]) send_byte(seq_zero[i]);
    write_marker(8'hFF);
    foreach (seq_ones[i]) send_byte(seq_ones[i]);

    markers[2] = 8'($urandom_range(2, 254));
    markers[4] = 8'($urandom_range(2, 254));
    useful_items = 0;
    for (int p = 0; p < 6; p++) begin
      write_marker(markers[p]);
      steady = (p == 2);
      target = QUOTA * (p + 1) / 6;
      while (useful_items < target) run_frame();
    end
    steady = 1'b0;

    drain();
    repeat (SETTLE) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/cfd_pkg.sv
rtl/cfd_ifs.sv
rtl/cfd_in_stage.sv
rtl/cfd_decode.sv
rtl/cfd_out_stage.sv
rtl/cobs_frame_decoder_top.sv
rtl/cfd_checker.sv
tb/testbench.sv
